// ===== design/tdp_pkg.sv =====
// ---------------------------------------------------------------------------
// tdp_pkg
// Shared types, character codes and limits for the time-of-day text parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdp_pkg;

  // Field being filled
  localparam logic [1:0] FLD_HOUR   = 2'd0;
  localparam logic [1:0] FLD_MINUTE = 2'd1;
  localparam logic [1:0] FLD_SECOND = 2'd2;
  localparam logic [1:0] FLD_SUFFIX = 2'd3;

  // Latin-1 character codes
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_LOW_P   = 8'h70;
  localparam logic [7:0] CH_UP_P    = 8'h50;
  localparam logic [7:0] CH_LOW_M   = 8'h6D;
  localparam logic [7:0] CH_UP_M    = 8'h4D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NBSP    = 8'hA0;

  // Limits on a freshly accumulated field value
  localparam logic [9:0] HOUR_LIMIT = 10'd23;
  localparam logic [9:0] MIN_LIMIT  = 10'd59;

  // Twelve-hour conversion
  localparam logic [4:0] HOUR_NOON   = 5'd12;
  localparam logic [4:0] HOUR_AM_MAX = 5'd11;

  localparam logic [10:0] MIN_PER_HOUR = 11'd60;

  // One result word
  typedef struct packed {
    logic        valid_res;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [10:0] minute_of_day;
  } res_t;

  // Whitespace: tab to carriage return, space, no-break space
  function automatic logic is_blank(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE) || (c == CH_NBSP);
  endfunction

endpackage

// ===== design/tdp_parse.sv =====
// ---------------------------------------------------------------------------
// tdp_parse
// Parser state and its update for one character; forms the
// result word from the updated state on the final character.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdp_parse (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     ch,
  input  logic           last,
  output tdp_pkg::res_t  res
);
  import tdp_pkg::*;

  logic [1:0] field_index, field_index_next;
  logic [1:0] digit_count, digit_count_next;
  logic [6:0] accumulator, accumulator_next;
  logic [4:0] hour_reg, hour_reg_next;
  logic [5:0] minute_reg, minute_reg_next;
  logic [5:0] second_reg, second_reg_next;
  logic       failed, failed_next;
  logic       suffix_seen, suffix_seen_next;

  logic       is_digit;
  logic       is_am;
  logic       is_pm;
  logic [9:0] acc10;
  logic [9:0] limit;

  assign is_digit = (ch >= CH_DIGIT_0) && (ch <= CH_DIGIT_9);
  assign is_am    = (ch == CH_LOW_A) || (ch == CH_UP_A);
  assign is_pm    = (ch == CH_LOW_P) || (ch == CH_UP_P);
  assign acc10    = ({3'b000, accumulator} << 3) + ({3'b000, accumulator} << 1)
                  + {6'd0, ch[3:0]};
  assign limit    = (field_index == FLD_HOUR) ? HOUR_LIMIT : MIN_LIMIT;

  // Consume one character
  always_comb begin
    field_index_next = field_index;
    digit_count_next = digit_count;
    accumulator_next = accumulator;
    hour_reg_next    = hour_reg;
    minute_reg_next  = minute_reg;
    second_reg_next  = second_reg;
    failed_next      = failed;
    suffix_seen_next = suffix_seen;
    if (!failed) begin
      priority if (suffix_seen) begin
        if (!(last && ((ch == CH_LOW_M) || (ch == CH_UP_M)))) failed_next = 1'b1;
      end else if (is_blank(ch)) begin
        failed_next = failed;
      end else if (is_digit) begin
        digit_count_next = digit_count + 2'd1;
        if ((field_index == FLD_SUFFIX) || (digit_count > 2'd1) || (acc10 > limit)) begin
          failed_next = 1'b1;
        end else begin
          accumulator_next = acc10[6:0];
          unique case (field_index)
            FLD_HOUR:   hour_reg_next   = acc10[4:0];
            FLD_MINUTE: minute_reg_next = acc10[5:0];
            default:    second_reg_next = acc10[5:0];
          endcase
        end
      end else if (ch == CH_COLON) begin
        if ((field_index > FLD_MINUTE) || (digit_count == 2'd0)) begin
          failed_next = 1'b1;
        end else begin
          accumulator_next = 7'd0;
          digit_count_next = 2'd0;
          field_index_next = field_index + 2'd1;
        end
      end else if (is_am || is_pm) begin
        if ((field_index == FLD_HOUR) && (digit_count == 2'd0)) begin
          failed_next = 1'b1;
        end else begin
          accumulator_next = 7'd0;
          digit_count_next = 2'd0;
          field_index_next = FLD_SUFFIX;
          suffix_seen_next = 1'b1;
          priority if (hour_reg == HOUR_NOON) begin
            if (is_am) hour_reg_next = 5'd0;
          end else if (hour_reg > HOUR_AM_MAX) begin
            failed_next = 1'b1;
          end else begin
            if (is_pm) hour_reg_next = hour_reg + HOUR_NOON;
          end
        end
      end else begin
        failed_next = 1'b1;
      end
    end
  end

  // Form the result word from the updated state
  always_comb begin
    res = '0;
    if (!failed_next) begin
      res.valid_res     = 1'b1;
      res.hour          = hour_reg_next;
      res.minute        = minute_reg_next;
      res.second        = second_reg_next;
      res.minute_of_day = ({6'd0, hour_reg_next} * MIN_PER_HOUR) + {5'd0, minute_reg_next};
    end
  end

  // Advance on each character; clear after the final one
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      field_index <= FLD_HOUR;
      digit_count <= 2'd0;
      accumulator <= 7'd0;
      hour_reg    <= 5'd0;
      minute_reg  <= 6'd0;
      second_reg  <= 6'd0;
      failed      <= 1'b0;
      suffix_seen <= 1'b0;
    end else if (step) begin
      field_index <= field_index_next;
      digit_count <= digit_count_next;
      accumulator <= accumulator_next;
      hour_reg    <= hour_reg_next;
      minute_reg  <= minute_reg_next;
      second_reg  <= second_reg_next;
      failed      <= failed_next;
      suffix_seen <= suffix_seen_next;
    end
  end

  a_suffix_field: assert property (@(posedge clk) disable iff (rst)
    (suffix_seen && !failed) |-> (field_index == FLD_SUFFIX))
    else $error("suffix seen outside suffix field");
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    !failed |-> (hour_reg <= HOUR_LIMIT[4:0]))
    else $error("hour out of range while parsing");
  a_min_range: assert property (@(posedge clk) disable iff (rst)
    !failed |-> ((minute_reg <= MIN_LIMIT[5:0]) && (second_reg <= MIN_LIMIT[5:0])))
    else $error("minute or second out of range while parsing");

endmodule

// ===== design/tdp_result.sv =====
// ---------------------------------------------------------------------------
// tdp_result
// Output register: holds one result word until the consumer takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdp_result (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  tdp_pkg::res_t  res_in,
  input  logic           out_stall,
  output logic           out_valid,
  output tdp_pkg::res_t  res_q
);
  import tdp_pkg::*;

  // Hold the word while stalled, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || !out_stall))
    else $error("result word overwritten while stalled");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_q.valid_res) |->
      ((res_q.hour == 5'd0) && (res_q.minute == 6'd0) && (res_q.second == 6'd0)
       && (res_q.minute_of_day == 11'd0)))
    else $error("failed result carries non-zero fields");
  a_mod_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (res_q.minute_of_day == ({6'd0, res_q.hour} * MIN_PER_HOUR) + {5'd0, res_q.minute}))
    else $error("minute of day inconsistent with hour and minute");

endmodule

// ===== design/time_of_day_text_parser.sv =====
// ---------------------------------------------------------------------------
// time_of_day_text_parser
// Parses a time string, one Latin-1 character per word, into hour, minute,
// second and minute of day, with a pass/fail flag on the final character.
// ---------------------------------------------------------------------------
//  channel | words                                   | handshake
//  --------+-----------------------------------------+---------------------
//  input   | ch, last                                | in_valid / in_stall
//  output  | valid_res, hour, minute, second,        | out_valid / out_stall
//          | minute_of_day                           |
//
//  One character per cycle unless a final character waits on a stalled
//  result: input register, parse logic, then the output register. The
//  result of the final character is registered in the output register.
//  Synchronous reset clears the parser state and both valid flags.
//  A stalled result holds only characters marked last; others keep flowing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_of_day_text_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        valid_res,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [10:0] minute_of_day
);
  import tdp_pkg::*;

  logic       ir_valid;
  logic [7:0] ir_ch;
  logic       ir_last;
  logic       step;
  res_t       res;
  res_t       res_q;

  // Parse the held character unless its result would have nowhere to go
  assign step     = ir_valid && (!ir_last || !out_valid || !out_stall);
  assign in_stall = ir_valid && !step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (!in_stall) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_ch   <= ch;
      ir_last <= last;
    end
  end

  tdp_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ch   (ir_ch),
    .last (ir_last),
    .res  (res)
  );

  tdp_result u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (step && ir_last),
    .res_in    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign valid_res     = res_q.valid_res;
  assign hour          = res_q.hour;
  assign minute        = res_q.minute;
  assign second        = res_q.second;
  assign minute_of_day = res_q.minute_of_day;

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (ir_valid && ir_last && out_valid))
    else $error("input stalled without a pending final character");
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    (ir_valid && !step) |=> (ir_valid && $stable(ir_ch) && $stable(ir_last)))
    else $error("held character lost");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (step && ir_last) |=> out_valid)
    else $error("final character produced no result");

endmodule
